/* src/process_table_scheduler_unit_macros.svh */
// Assertion macros for the process table scheduler checker.
`ifndef PROCESS_TABLE_SCHEDULER_UNIT_MACROS_SVH
`define PROCESS_TABLE_SCHEDULER_UNIT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define PTSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define PTSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Next-cycle implication that also covers reset itself.
`define PTSU_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

/* src/ptsu_pkg.sv */
// Shared types, constants and helpers of the process table scheduler.
package ptsu_pkg;
  localparam int ID_W   = 7;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 1;
  localparam logic [CNT_W-1:0] SAT_MAX = 16'hFFFF;

  localparam logic [IDX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [IDX_W-1:0] REG_SLICE  = 1'd1;

  typedef enum logic [1:0] {
    POL_PID   = 2'd0,
    POL_BURST = 2'd1,
    POL_PRIO  = 2'd2,
    POL_RR    = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_DONE  = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    RES_DISPATCHED = 2'd0,
    RES_IDLE       = 2'd1,
    RES_INSERTED   = 2'd2,
    RES_FULL       = 2'd3
  } res_t;

  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_DRAIN, S_DECIDE, S_FETCH,
    S_TAKE, S_UPDATE, S_UPD_DRAIN, S_FINISH
  } state_t;

  typedef struct packed {
    logic in_open;
    logic load_item;
    logic scan_init;
    logic scan_run;
    logic fetch;
    logic take_rem;
    logic upd_init;
    logic upd_run;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic found;
    logic walk_last;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [ID_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W+1-ID_W){1'b0}}, b};
    return s[CNT_W] ? SAT_MAX : s[CNT_W-1:0];
  endfunction
endpackage

/* src/ptsu_req_if.sv */
// Request channel: insert or dispatch items.
interface ptsu_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [ptsu_pkg::ID_W-1:0] proc_id;
  logic [ptsu_pkg::ID_W-1:0] burst_len;
  logic [ptsu_pkg::ID_W-1:0] prio_level;
  modport source (output valid, mode, proc_id, burst_len, prio_level, input ready);
  modport sink (input valid, mode, proc_id, burst_len, prio_level, output ready);
endinterface

/* src/ptsu_rsp_if.sv */
// Response channel: one result per request.
interface ptsu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [ptsu_pkg::ID_W-1:0]  run_id;
  logic [ptsu_pkg::ID_W-1:0]  run_slice;
  logic                       run_done;
  logic [ptsu_pkg::CNT_W-1:0] run_turnaround;
  logic [ptsu_pkg::CNT_W-1:0] run_waiting;
  logic [ptsu_pkg::CNT_W-1:0] idle_total;
  modport source (output valid, status, run_id, run_slice, run_done, run_turnaround,
                  run_waiting, idle_total, input ready);
  modport sink (input valid, status, run_id, run_slice, run_done, run_turnaround,
                run_waiting, idle_total, output ready);
endinterface

/* src/ptsu_cfg_if.sv */
// Configuration write channel.
interface ptsu_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ptsu_pkg::IDX_W-1:0] index;
  logic [ptsu_pkg::ID_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/process_table_scheduler_unit.sv */
// Process table scheduler: insert processes, dispatch them by policy.
// An insert loads its result directly; a dispatch scans the table, fetches the chosen slot
// and runs the aging pass, or skips both when nothing is ready. The scan and the aging pass
// each walk the table one slot per cycle. One transaction at a time: the next request is
// taken in the cycle after the result is loaded, which waits while an older one is unread.
// Reset (rst, synchronous): empties all slots, clears counters, restores policy and quantum.
module process_table_scheduler_unit #(
  parameter int ENTRIES = 16
) (
  input logic        clk,
  input logic        rst,
  ptsu_req_if.sink   req,
  ptsu_rsp_if.source rsp,
  ptsu_cfg_if.sink   cfg
);
  import ptsu_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequence transactions: a dispatch scans, then fetches and ages if found; each reports.
  ptsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the table, pick the winner, apply saturating counters.
  ptsu_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );
endmodule

/* src/ptsu_ctrl.sv */
// Sequencing state machine of the process table scheduler.
module ptsu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_mode,
  input  ptsu_pkg::ctl_sts_t  sts,
  output ptsu_pkg::ctl_cmd_t  cmd
);
  import ptsu_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = (state == S_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (accept) state_next = (in_mode == MODE_DISPATCH) ? S_SCAN : S_FINISH;
      S_SCAN:       if (sts.walk_last) state_next = S_SCAN_DRAIN;
      S_SCAN_DRAIN: state_next = S_DECIDE;
      S_DECIDE:     state_next = sts.found ? S_FETCH : S_FINISH;
      S_FETCH:      state_next = S_TAKE;
      S_TAKE:       state_next = S_UPDATE;
      S_UPDATE:     if (sts.walk_last) state_next = S_UPD_DRAIN;
      S_UPD_DRAIN:  state_next = S_FINISH;
      S_FINISH:     if (sts.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.in_open   = 1'b1;
        cmd.load_item = accept;
        cmd.scan_init = accept;
      end
      S_SCAN:   cmd.scan_run = 1'b1;
      S_FETCH:  cmd.fetch = 1'b1;
      S_TAKE: begin
        cmd.take_rem = 1'b1;
        cmd.upd_init = 1'b1;
      end
      S_UPDATE: cmd.upd_run = 1'b1;
      S_FINISH: cmd.finish = sts.out_free;
      default:  cmd = '0;
    endcase
  end
endmodule

/* src/ptsu_datapath.sv */
// Table storage, scan, update pass and result register.
module ptsu_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ptsu_pkg::ctl_cmd_t cmd,
  output ptsu_pkg::ctl_sts_t sts,
  ptsu_req_if.sink           req,
  ptsu_rsp_if.source         rsp,
  ptsu_cfg_if.sink           cfg
);
  import ptsu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = 3 * ID_W;
  localparam int RW = ID_W + 2 * CNT_W;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  // item and configuration
  logic            mode_q;
  logic [ID_W-1:0] pid_q, burst_q, prio_q;
  policy_t         policy;
  logic [ID_W-1:0] tslice;

  // table state
  slot_st_t        slot_st [ENTRIES];
  logic [CW-1:0]   count;
  logic [IW-1:0]   rr_pos;
  logic [CNT_W-1:0] idle_cnt;
  logic [KW-1:0]   key_mem [ENTRIES];
  logic [RW-1:0]   run_mem [ENTRIES];
  logic [KW-1:0]   key_rd;
  logic [RW-1:0]   run_rd;

  // walk and selection
  logic [IW-1:0]   waddr, wcnt, a1, best;
  logic            s1, u1, found;
  logic [ID_W-1:0] best_key, best_pid;
  logic [ID_W-1:0] slice_q, nrem_q;
  logic            done_q;
  logic [CNT_W-1:0] res_tat, res_wt;

  // result register
  logic            out_valid;
  res_t            out_status;
  logic [ID_W-1:0] out_id, out_slice;
  logic            out_done;
  logic [CNT_W-1:0] out_tat, out_wt, out_idle;

  logic [IW-1:0]   next_addr, start_addr, run_raddr, run_waddr;
  logic            has_room, ins_we, upd_we, run_we, hit, at_best;
  slot_st_t        st_a1;
  logic [ID_W-1:0] key_cur, rem_cur;
  logic [CNT_W-1:0] tat_cur, wt_cur, tat_inc, wt_inc, idle_inc;
  logic [RW-1:0]   run_wdata;

  assign req.ready = cmd.in_open;
  assign cfg.ready = 1'b1;

  assign next_addr  = (waddr == LAST) ? '0 : waddr + 1'b1;
  assign start_addr = (policy == POL_RR) ? ((rr_pos == LAST) ? '0 : rr_pos + 1'b1) : '0;
  assign has_room   = count < FULL;
  assign ins_we     = cmd.finish && (mode_q == MODE_INSERT) && has_room;

  assign st_a1   = slot_st[a1];
  assign at_best = (a1 == best);
  always_comb begin
    case (policy)
      POL_PID:   key_cur = key_rd[KW-1 -: ID_W];
      POL_BURST: key_cur = key_rd[2*ID_W-1 -: ID_W];
      POL_PRIO:  key_cur = key_rd[ID_W-1:0];
      default:   key_cur = '0;
    endcase
  end
  assign hit = s1 && (st_a1 == SLOT_READY) && (!found || key_cur < best_key);

  assign rem_cur = run_rd[RW-1 -: ID_W];
  assign tat_cur = run_rd[2*CNT_W-1 -: CNT_W];
  assign wt_cur  = run_rd[CNT_W-1:0];
  assign tat_inc = sat_add(tat_cur, slice_q);
  assign wt_inc  = sat_add(wt_cur, slice_q);
  assign upd_we  = u1 && (at_best || st_a1 == SLOT_READY);
  assign run_we  = ins_we || upd_we;
  assign idle_inc = sat_add(idle_cnt, ID_W'(1));

  always_comb begin
    if (ins_we) begin
      run_waddr = count[IW-1:0];
      run_wdata = {burst_q, {CNT_W{1'b0}}, {CNT_W{1'b0}}};
    end else begin
      run_waddr = a1;
      run_wdata = at_best ? {nrem_q, tat_inc, wt_cur} : {rem_cur, tat_inc, wt_inc};
    end
  end
  assign run_raddr = cmd.fetch ? best : waddr;

  always_ff @(posedge clk) begin
    if (ins_we) key_mem[count[IW-1:0]] <= {pid_q, burst_q, prio_q};
    key_rd <= key_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (run_we) run_mem[run_waddr] <= run_wdata;
    run_rd <= run_mem[run_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_q  <= req.mode;
      pid_q   <= req.proc_id;
      burst_q <= req.burst_len;
      prio_q  <= req.prio_level;
    end
    a1 <= waddr;
    if (hit) begin
      best     <= a1;
      best_key <= key_cur;
      best_pid <= key_rd[KW-1 -: ID_W];
    end
    if (cmd.take_rem) begin
      if (policy == POL_RR && rem_cur > tslice) begin
        slice_q <= tslice;
        nrem_q  <= rem_cur - tslice;
        done_q  <= 1'b0;
      end else begin
        slice_q <= rem_cur;
        nrem_q  <= '0;
        done_q  <= 1'b1;
      end
    end
    if (u1 && at_best) begin
      res_tat <= tat_inc;
      res_wt  <= wt_cur;
    end
    if (cmd.scan_init || cmd.upd_init) begin
      waddr <= cmd.scan_init ? start_addr : '0;
      wcnt  <= '0;
    end else if (cmd.scan_run || cmd.upd_run) begin
      waddr <= next_addr;
      wcnt  <= wcnt + 1'b1;
    end
    if (cmd.finish) begin
      out_idle <= idle_cnt;
      out_id   <= '0;
      out_slice <= '0;
      out_done <= 1'b0;
      out_tat  <= '0;
      out_wt   <= '0;
      if (mode_q == MODE_INSERT) begin
        out_status <= has_room ? RES_INSERTED : RES_FULL;
      end else if (!found) begin
        out_status <= RES_IDLE;
        out_idle   <= idle_inc;
      end else begin
        out_status <= RES_DISPATCHED;
        out_id     <= best_pid;
        out_slice  <= slice_q;
        out_done   <= done_q;
        out_tat    <= res_tat;
        out_wt     <= res_wt;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POL_PID;
      tslice    <= ID_W'(1);
      count     <= '0;
      rr_pos    <= '0;
      idle_cnt  <= '0;
      s1        <= 1'b0;
      u1        <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) slot_st[i] <= SLOT_EMPTY;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_POLICY: policy <= policy_t'(cfg.data[1:0]);
          REG_SLICE:  tslice <= cfg.data;
          default:    ;
        endcase
      end
      s1 <= cmd.scan_run;
      u1 <= cmd.upd_run;
      if (cmd.scan_init)  found <= 1'b0;
      else if (hit)       found <= 1'b1;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (ins_we) begin
          slot_st[count[IW-1:0]] <= SLOT_READY;
          count <= count + 1'b1;
        end else if (mode_q == MODE_DISPATCH) begin
          if (!found) idle_cnt <= idle_inc;
          else begin
            rr_pos <= best;
            if (done_q) slot_st[best] <= SLOT_DONE;
          end
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.found     = found;
  assign sts.walk_last = (wcnt == LAST);
  assign sts.out_free  = !out_valid || rsp.ready;

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.run_id         = out_id;
  assign rsp.run_slice      = out_slice;
  assign rsp.run_done       = out_done;
  assign rsp.run_turnaround = out_tat;
  assign rsp.run_waiting    = out_wt;
  assign rsp.idle_total     = out_idle;
endmodule

/* src/ptsu_checker.sv */
// Port-level checks of the process table scheduler and their binding.
`include "process_table_scheduler_unit_macros.svh"
module ptsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [6:0]  run_id,
  input logic [6:0]  run_slice,
  input logic        run_done,
  input logic [15:0] run_tat,
  input logic [15:0] run_wt
);
  import ptsu_pkg::*;

  `PTSU_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `PTSU_ASSERT_NOW(a_zero_fields, out_valid && out_status != RES_DISPATCHED, run_id == 0 && run_slice == 0 && !run_done && run_tat == 0 && run_wt == 0, "nonzero run fields without dispatch")
  `PTSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped while stalled")
  `PTSU_ASSERT_RST(a_reset_empty, rst, !out_valid, "result pending after reset")
endmodule

bind process_table_scheduler_unit ptsu_checker u_ptsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_status (rsp.status),
  .run_id     (rsp.run_id),
  .run_slice  (rsp.run_slice),
  .run_done   (rsp.run_done),
  .run_tat    (rsp.run_turnaround),
  .run_wt     (rsp.run_waiting)
);
